[src/cttr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttr_pkg
// Shared types, codes and defaults for the contactless tag target responder.
// ----------------------------------------------------------------------------
package cttr_pkg;

  localparam int BLOCK_COUNT_DEF  = 131;
  localparam int SYSTEM_BLOCK_DEF = 128;
  localparam int UID_BLOCK_DEF    = 129;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHIP_ID_RESET = 8'h42;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [7:0] OP_INITIATE   = 8'h06;
  localparam logic [7:0] OP_SELECT     = 8'h0e;
  localparam logic [7:0] OP_SLOT_MASK  = 8'h0f;
  localparam logic [7:0] OP_SLOT_CODE  = 8'h06;
  localparam logic [7:0] OP_READ       = 8'h08;
  localparam logic [7:0] OP_WRITE      = 8'h09;
  localparam logic [7:0] OP_GET_UID    = 8'h0b;
  localparam logic [7:0] OP_RESET_INV  = 8'h0c;
  localparam logic [7:0] OP_COMPLETION = 8'h0f;

  localparam logic [7:0]  SAVE_ADDR  = 8'hfe;
  localparam logic [7:0]  ALIAS_ADDR = 8'hff;
  localparam logic [63:0] OK_CODE    = 64'h0000_0000_bebafeca;

  localparam logic [1:0] DLY_NONE   = 2'd0;
  localparam logic [1:0] DLY_GLOBAL = 2'd1;
  localparam logic [1:0] DLY_SMALL  = 2'd2;
  localparam logic [1:0] DLY_MEDIUM = 2'd3;

  localparam logic [3:0] LEN_NONE  = 4'd0;
  localparam logic [3:0] LEN_CHIP  = 4'd1;
  localparam logic [3:0] LEN_BLOCK = 4'd4;
  localparam logic [3:0] LEN_UID   = 4'd8;

  typedef enum logic [2:0] {
    ST_POWEROFF    = 3'd0,
    ST_READY       = 3'd1,
    ST_INVENTORY   = 3'd2,
    ST_SELECTED    = 3'd3,
    ST_DESELECTED  = 3'd4,
    ST_DEACTIVATED = 3'd5,
    ST_INVALID     = 3'd6
  } proto_state_t;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_UID   = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_READ   = 2'd1,
    BK_UID_LO = 2'd2,
    BK_UID_HI = 2'd3
  } back_state_t;

  typedef struct packed {
    proto_state_t new_state;
    logic [3:0]   rlen;
    logic [63:0]  rdata;
    logic [1:0]   dly;
    logic         save;
    logic         rearm;
  } result_t;

  typedef struct packed {
    op_kind_t    kind;
    result_t     res;
    logic [7:0]  addr;
    logic [31:0] wdata;
  } entry_t;

endpackage

[src/cttr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttr_front
// Accepts requests, runs the protocol state machine and classifies each
// request into a store operation with its preformed result.
// ----------------------------------------------------------------------------
module cttr_front #(
  parameter int BLOCK_COUNT  = cttr_pkg::BLOCK_COUNT_DEF,
  parameter int SYSTEM_BLOCK = cttr_pkg::SYSTEM_BLOCK_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_frame_length,
  input  logic [7:0]       in_first_byte,
  input  logic [7:0]       in_second_byte,
  input  logic [31:0]      in_data_word,
  input  logic [7:0]       in_load_index,
  input  logic             q_full,
  output logic             q_push,
  output cttr_pkg::entry_t q_entry
);

  localparam logic [8:0] BC_L  = 9'(BLOCK_COUNT);
  localparam logic [7:0] SYS_L = 8'(SYSTEM_BLOCK);

  cttr_pkg::proto_state_t state_r, state_nxt, state_dec;
  logic [7:0] chip_id_r, chip_id_nxt;
  logic [7:0] idx;
  logic       idx_ok, lidx_ok;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign idx     = (in_second_byte == cttr_pkg::ALIAS_ADDR) ? SYS_L : in_second_byte;
  assign idx_ok  = ({1'b0, idx} < BC_L);
  assign lidx_ok = ({1'b0, in_load_index} < BC_L);

  always_comb begin
    state_dec = state_r;
    case (in_command)
      cttr_pkg::CMD_FRAME: begin
        case (state_r)
          cttr_pkg::ST_POWEROFF, cttr_pkg::ST_READY: begin
            if (in_frame_length == 8'd2 && in_first_byte == cttr_pkg::OP_INITIATE) begin
              state_dec = cttr_pkg::ST_INVENTORY;
            end else begin
              state_dec = cttr_pkg::ST_INVALID;
            end
          end
          cttr_pkg::ST_INVENTORY, cttr_pkg::ST_DESELECTED: begin
            if (in_frame_length == 8'd2 && in_first_byte == cttr_pkg::OP_SELECT) begin
              if (in_second_byte == chip_id_r) state_dec = cttr_pkg::ST_SELECTED;
            end else if (in_frame_length != 8'd0 &&
                         (in_first_byte & cttr_pkg::OP_SLOT_MASK) == cttr_pkg::OP_SLOT_CODE) begin
              state_dec = state_r;
            end else begin
              state_dec = cttr_pkg::ST_POWEROFF;
            end
          end
          cttr_pkg::ST_SELECTED: begin
            if (in_frame_length == 8'd1) begin
              if (in_first_byte == cttr_pkg::OP_RESET_INV) begin
                state_dec = cttr_pkg::ST_INVENTORY;
              end else if (in_first_byte == cttr_pkg::OP_COMPLETION) begin
                state_dec = cttr_pkg::ST_DEACTIVATED;
              end
            end
          end
          default: state_dec = cttr_pkg::ST_POWEROFF;
        endcase
      end
      cttr_pkg::CMD_RESET: state_dec = cttr_pkg::ST_POWEROFF;
      default:             state_dec = state_r;
    endcase
    state_nxt = q_push ? state_dec : state_r;
  end

  always_comb begin
    q_entry           = '0;
    q_entry.kind      = cttr_pkg::KIND_PLAIN;
    q_entry.addr      = idx;
    q_entry.wdata     = in_data_word;
    q_entry.res.new_state = state_dec;
    case (in_command)
      cttr_pkg::CMD_FRAME: begin
        case (state_r)
          cttr_pkg::ST_POWEROFF, cttr_pkg::ST_READY: begin
            if (in_frame_length == 8'd2 && in_first_byte == cttr_pkg::OP_INITIATE) begin
              q_entry.res.rlen  = cttr_pkg::LEN_CHIP;
              q_entry.res.rdata = {56'd0, chip_id_r};
              q_entry.res.dly   = cttr_pkg::DLY_MEDIUM;
            end
          end
          cttr_pkg::ST_INVENTORY, cttr_pkg::ST_DESELECTED: begin
            if ((in_frame_length == 8'd2 && in_first_byte == cttr_pkg::OP_SELECT) ||
                (in_frame_length != 8'd0 &&
                 (in_first_byte & cttr_pkg::OP_SLOT_MASK) == cttr_pkg::OP_SLOT_CODE)) begin
              q_entry.res.rlen  = cttr_pkg::LEN_CHIP;
              q_entry.res.rdata = {56'd0, chip_id_r};
              q_entry.res.dly   = cttr_pkg::DLY_MEDIUM;
            end
          end
          cttr_pkg::ST_SELECTED: begin
            if (in_frame_length == 8'd1 && in_first_byte == cttr_pkg::OP_GET_UID) begin
              q_entry.kind     = cttr_pkg::KIND_UID;
              q_entry.res.rlen = cttr_pkg::LEN_UID;
              q_entry.res.dly  = cttr_pkg::DLY_GLOBAL;
            end else if (in_frame_length == 8'd2 && in_first_byte == cttr_pkg::OP_READ &&
                         idx_ok) begin
              q_entry.kind     = cttr_pkg::KIND_READ;
              q_entry.res.rlen = cttr_pkg::LEN_BLOCK;
              q_entry.res.dly  = cttr_pkg::DLY_SMALL;
            end else if (in_frame_length == 8'd6 && in_first_byte == cttr_pkg::OP_WRITE) begin
              if (idx_ok) begin
                q_entry.kind = cttr_pkg::KIND_WRITE;
              end else if (idx == cttr_pkg::SAVE_ADDR) begin
                q_entry.res.save  = 1'b1;
                q_entry.res.rlen  = cttr_pkg::LEN_BLOCK;
                q_entry.res.rdata = cttr_pkg::OK_CODE;
                q_entry.res.dly   = cttr_pkg::DLY_GLOBAL;
              end
            end
          end
          default: q_entry.kind = cttr_pkg::KIND_PLAIN;
        endcase
        q_entry.res.rearm = (q_entry.res.rlen == cttr_pkg::LEN_NONE) &&
                            (state_dec != cttr_pkg::ST_INVALID);
      end
      cttr_pkg::CMD_LOAD: begin
        q_entry.addr = in_load_index;
        if (lidx_ok) q_entry.kind = cttr_pkg::KIND_WRITE;
      end
      default: q_entry.kind = cttr_pkg::KIND_PLAIN;
    endcase
  end

  assign chip_id_nxt = cfg_we ? cfg_wdata : chip_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cttr_pkg::ST_POWEROFF;
      chip_id_r <= cttr_pkg::CHIP_ID_RESET;
    end else begin
      state_r   <= state_nxt;
      chip_id_r <= chip_id_nxt;
    end
  end

endmodule

[src/cttr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttr_queue
// Short first-in first-out queue of classified operations.
// ----------------------------------------------------------------------------
module cttr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cttr_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output cttr_pkg::entry_t head_entry
);

  cttr_pkg::entry_t slot_r [cttr_pkg::QUEUE_DEPTH];
  logic [cttr_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [cttr_pkg::QCNT_W-1:0] count_r, count_nxt;

  localparam logic [cttr_pkg::QCNT_W-1:0] DEPTH_L = cttr_pkg::QCNT_W'(cttr_pkg::QUEUE_DEPTH);

  assign full       = (count_r == DEPTH_L);
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/cttr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttr_back
// Executes queued operations against the block store and drives the result
// register.
// ----------------------------------------------------------------------------
module cttr_back #(
  parameter int BLOCK_COUNT = cttr_pkg::BLOCK_COUNT_DEF,
  parameter int UID_BLOCK   = cttr_pkg::UID_BLOCK_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cttr_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cttr_pkg::result_t out_res
);

  localparam int ADDR_W = $clog2(BLOCK_COUNT);
  localparam logic [ADDR_W-1:0] UID_LO_A = ADDR_W'(UID_BLOCK);
  localparam logic [ADDR_W-1:0] UID_HI_A = ADDR_W'(UID_BLOCK + 1);
  localparam bit UID_LO_OK = (UID_BLOCK < BLOCK_COUNT);
  localparam bit UID_HI_OK = (UID_BLOCK + 1 < BLOCK_COUNT);

  cttr_pkg::back_state_t state_r, state_nxt;
  cttr_pkg::result_t     hold_r, out_r, out_load_val;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           lo_r;
  logic [31:0]           mem [BLOCK_COUNT];
  logic [31:0]           mem_q;
  logic                  out_free, out_load, hold_load, lo_load;
  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     rd_addr;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cttr_pkg::BK_IDLE: begin
        if (q_valid && q_entry.kind == cttr_pkg::KIND_READ) state_nxt = cttr_pkg::BK_READ;
        if (q_valid && q_entry.kind == cttr_pkg::KIND_UID)  state_nxt = cttr_pkg::BK_UID_LO;
      end
      cttr_pkg::BK_READ:   if (out_free) state_nxt = cttr_pkg::BK_IDLE;
      cttr_pkg::BK_UID_LO: state_nxt = cttr_pkg::BK_UID_HI;
      cttr_pkg::BK_UID_HI: if (out_free) state_nxt = cttr_pkg::BK_IDLE;
      default:             state_nxt = cttr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    out_load     = 1'b0;
    out_load_val = hold_r;
    hold_load    = 1'b0;
    lo_load      = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    rd_addr      = q_entry.addr[ADDR_W-1:0];
    case (state_r)
      cttr_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_entry.kind)
            cttr_pkg::KIND_READ: begin
              q_pop     = 1'b1;
              hold_load = 1'b1;
              rd_en     = 1'b1;
            end
            cttr_pkg::KIND_UID: begin
              q_pop     = 1'b1;
              hold_load = 1'b1;
              rd_en     = UID_LO_OK;
              rd_addr   = UID_LO_A;
            end
            default: begin
              q_pop        = out_free;
              out_load     = out_free;
              out_load_val = q_entry.res;
              wr_en        = out_free && (q_entry.kind == cttr_pkg::KIND_WRITE);
            end
          endcase
        end
      end
      cttr_pkg::BK_READ: begin
        out_load           = out_free;
        out_load_val.rdata = {32'd0, mem_q};
      end
      cttr_pkg::BK_UID_LO: begin
        lo_load = 1'b1;
        rd_en   = UID_HI_OK;
        rd_addr = UID_HI_A;
      end
      cttr_pkg::BK_UID_HI: begin
        out_load           = out_free;
        out_load_val.rdata = {(UID_HI_OK ? mem_q : 32'd0), lo_r};
      end
      default: out_load = 1'b0;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[q_entry.addr[ADDR_W-1:0]] <= q_entry.wdata;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (hold_load) hold_r <= q_entry.res;
    if (lo_load)   lo_r   <= UID_LO_OK ? mem_q : 32'd0;
    if (out_load)  out_r  <= out_load_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cttr_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/contactless_tag_target_responder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contactless_tag_target_responder_top
// Plain and write requests go from the queue straight into the result register;
// block reads first read the store, UID reads read two words (low, then high)
// over the one store port. Plain and write requests go one per cycle while the
// result register is free; a block or UID read holds the queue until its result loads.
// Reset (synchronous, active low): power off state, chip id 0x42, queue and
// result register empty; the block store is not cleared.
// ----------------------------------------------------------------------------
module contactless_tag_target_responder_top #(
  parameter int BLOCK_COUNT  = cttr_pkg::BLOCK_COUNT_DEF,
  parameter int SYSTEM_BLOCK = cttr_pkg::SYSTEM_BLOCK_DEF,
  parameter int UID_BLOCK    = cttr_pkg::UID_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_frame_length,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic [31:0] in_data_word,
  input  logic [7:0]  in_load_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_new_state,
  output logic [3:0]  out_response_length,
  output logic [63:0] out_response_data,
  output logic [1:0]  out_delay_class,
  output logic        out_save_request,
  output logic        out_rearm_receiver
);

  logic              q_full, q_push, q_pop, q_valid;
  cttr_pkg::entry_t  push_entry, head_entry;
  cttr_pkg::result_t res;

  cttr_front #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .SYSTEM_BLOCK(SYSTEM_BLOCK)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_frame_length(in_frame_length),
    .in_first_byte  (in_first_byte),
    .in_second_byte (in_second_byte),
    .in_data_word   (in_data_word),
    .in_load_index  (in_load_index),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (push_entry)
  );

  cttr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_entry(head_entry)
  );

  cttr_back #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .UID_BLOCK  (UID_BLOCK)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (head_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_new_state       = res.new_state;
  assign out_response_length = res.rlen;
  assign out_response_data   = res.rdata;
  assign out_delay_class     = res.dly;
  assign out_save_request    = res.save;
  assign out_rearm_receiver  = res.rearm;

endmodule

[src/cttr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttr_checker
// Port-level checks of the responder's result channel.
// ----------------------------------------------------------------------------
module cttr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_new_state,
  input logic [3:0]  out_response_length,
  input logic [63:0] out_response_data,
  input logic [1:0]  out_delay_class,
  input logic        out_save_request,
  input logic        out_rearm_receiver
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_response_data) &&
      $stable(out_new_state) && $stable(out_response_length))
    else $error("result changed while stalled");

  a_rearm_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rearm_receiver |->
      out_response_length == cttr_pkg::LEN_NONE && out_new_state != cttr_pkg::ST_INVALID)
    else $error("rearm with a reply or in invalid state");

  a_save_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_save_request |->
      out_response_length == cttr_pkg::LEN_BLOCK && out_response_data == cttr_pkg::OK_CODE &&
      out_new_state == cttr_pkg::ST_SELECTED)
    else $error("save request without OK reply");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_response_length == cttr_pkg::LEN_NONE |->
      out_response_data == 64'd0 && out_delay_class == cttr_pkg::DLY_NONE)
    else $error("no-reply result carries data or delay");

endmodule

bind contactless_tag_target_responder_top cttr_checker u_cttr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_new_state      (out_new_state),
  .out_response_length(out_response_length),
  .out_response_data  (out_response_data),
  .out_delay_class    (out_delay_class),
  .out_save_request   (out_save_request),
  .out_rearm_receiver (out_rearm_receiver)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contactless tag target responder. A shadow of
// the tag (protocol state, chip id, block store) predicts the reply to every
// accepted request; replies are checked in order, field by field. Stimulus is
// a directed pass over the protocol corners, then state-aware random traffic
// under several chip id settings and handshake idling modes, including one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import cttr_pkg::*;

  localparam int N_BLOCKS       = BLOCK_COUNT_DEF;
  localparam int SYS_BLOCK      = SYSTEM_BLOCK_DEF;
  localparam int UID_BLK        = UID_BLOCK_DEF;
  localparam int PHASE_REQUESTS = 320;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  frame_length;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [31:0] data_word;
    logic [7:0]  load_index;
  } tag_request_t;

  typedef struct packed {
    logic [2:0]  new_state;
    logic [3:0]  response_length;
    logic [63:0] response_data;
    logic [1:0]  delay_class;
    logic        save_request;
    logic        rearm_receiver;
  } tag_reply_t;

  class tag_shadow;
    logic [7:0]  chip_id;
    logic [2:0]  tag_state;
    logic [31:0] blocks [N_BLOCKS];
    bit          written [N_BLOCKS];
    tag_reply_t  pending [$];
    int errors, requests, chip_replies, uid_replies, block_replies, saves;

    function new();
      chip_id = CHIP_ID_RESET;
      tag_state = ST_POWEROFF;
      errors = 0;
      requests = 0;
      chip_replies = 0;
      uid_replies = 0;
      block_replies = 0;
      saves = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    static function int block_index(logic [7:0] a);
      return (a == ALIAS_ADDR) ? SYS_BLOCK : int'(a);
    endfunction

    // Index of a never-written block that this request would read, else -1.
    function int unread_block(tag_request_t r);
      int idx;
      if (r.command != CMD_FRAME || tag_state != ST_SELECTED) return -1;
      if (r.frame_length == 8'd1 && r.first_byte == OP_GET_UID) begin
        if (!written[UID_BLK]) return UID_BLK;
        if (!written[UID_BLK + 1]) return UID_BLK + 1;
      end
      if (r.frame_length == 8'd2 && r.first_byte == OP_READ) begin
        idx = block_index(r.second_byte);
        if (idx < N_BLOCKS && !written[idx]) return idx;
      end
      return -1;
    endfunction

    function void take_request(tag_request_t r);
      tag_reply_t e;
      logic [2:0] st;
      int idx;
      e = '0;
      st = tag_state;
      requests++;
      case (r.command)
        CMD_FRAME: begin
          case (st)
            ST_POWEROFF, ST_READY: begin
              if (r.frame_length == 8'd2 && r.first_byte == OP_INITIATE) begin
                st = ST_INVENTORY;
                e.response_length = LEN_CHIP;
                e.response_data = {56'd0, chip_id};
                e.delay_class = DLY_MEDIUM;
              end else begin
                st = ST_INVALID;
              end
            end
            ST_INVENTORY, ST_DESELECTED: begin
              if (r.frame_length == 8'd2 && r.first_byte == OP_SELECT) begin
                if (r.second_byte == chip_id) st = ST_SELECTED;
                e.response_length = LEN_CHIP;
                e.response_data = {56'd0, chip_id};
                e.delay_class = DLY_MEDIUM;
              end else if (r.frame_length >= 8'd1 &&
                           (r.first_byte & OP_SLOT_MASK) == OP_SLOT_CODE) begin
                e.response_length = LEN_CHIP;
                e.response_data = {56'd0, chip_id};
                e.delay_class = DLY_MEDIUM;
              end else begin
                st = ST_POWEROFF;
              end
            end
            ST_SELECTED: begin
              if (r.frame_length == 8'd1) begin
                if (r.first_byte == OP_GET_UID) begin
                  e.response_length = LEN_UID;
                  e.response_data = {blocks[UID_BLK + 1], blocks[UID_BLK]};
                  e.delay_class = DLY_GLOBAL;
                end else if (r.first_byte == OP_RESET_INV) begin
                  st = ST_INVENTORY;
                end else if (r.first_byte == OP_COMPLETION) begin
                  st = ST_DEACTIVATED;
                end
              end else if (r.frame_length == 8'd2) begin
                if (r.first_byte == OP_READ) begin
                  idx = block_index(r.second_byte);
                  if (idx < N_BLOCKS) begin
                    e.response_length = LEN_BLOCK;
                    e.response_data = {32'd0, blocks[idx]};
                    e.delay_class = DLY_SMALL;
                  end
                end
              end else if (r.frame_length == 8'd6 && r.first_byte == OP_WRITE) begin
                idx = block_index(r.second_byte);
                if (idx < N_BLOCKS) begin
                  blocks[idx] = r.data_word;
                  written[idx] = 1'b1;
                end else if (idx == int'(SAVE_ADDR)) begin
                  e.save_request = 1'b1;
                  e.response_length = LEN_BLOCK;
                  e.response_data = OK_CODE;
                  e.delay_class = DLY_GLOBAL;
                end
              end
            end
            default: st = ST_POWEROFF;
          endcase
          e.rearm_receiver = (e.response_length == LEN_NONE && st != ST_INVALID);
          tag_state = st;
        end
        CMD_LOAD: begin
          if (int'(r.load_index) < N_BLOCKS) begin
            blocks[r.load_index] = r.data_word;
            written[r.load_index] = 1'b1;
          end
        end
        CMD_RESET: begin
          tag_state = ST_POWEROFF;
          st = ST_POWEROFF;
        end
        default: ;
      endcase
      e.new_state = st;
      if (e.response_length == LEN_CHIP) chip_replies++;
      if (e.response_length == LEN_UID) uid_replies++;
      if (e.response_length == LEN_BLOCK && !e.save_request) block_replies++;
      if (e.save_request) saves++;
      pending.push_back(e);
    endfunction

    function void check_reply(tag_reply_t got);
      tag_reply_t e;
      if (pending.size() == 0) begin
        $error("reply with no request outstanding: state %0d length %0d data %h",
               got.new_state, got.response_length, got.response_data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.new_state !== e.new_state) begin
        $error("new_state: expected %0d, got %0d", e.new_state, got.new_state);
        errors++;
      end
      if (got.response_length !== e.response_length) begin
        $error("response_length: expected %0d, got %0d",
               e.response_length, got.response_length);
        errors++;
      end
      if (got.response_data !== e.response_data) begin
        $error("response_data: expected %h, got %h", e.response_data, got.response_data);
        errors++;
      end
      if (got.delay_class !== e.delay_class) begin
        $error("delay_class: expected %0d, got %0d", e.delay_class, got.delay_class);
        errors++;
      end
      if (got.save_request !== e.save_request) begin
        $error("save_request: expected %0d, got %0d", e.save_request, got.save_request);
        errors++;
      end
      if (got.rearm_receiver !== e.rearm_receiver) begin
        $error("rearm_receiver: expected %0d, got %0d",
               e.rearm_receiver, got.rearm_receiver);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [7:0]  in_frame_length = '0;
  logic [7:0]  in_first_byte = '0;
  logic [7:0]  in_second_byte = '0;
  logic [31:0] in_data_word = '0;
  logic [7:0]  in_load_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_new_state;
  logic [3:0]  out_response_length;
  logic [63:0] out_response_data;
  logic [1:0]  out_delay_class;
  logic        out_save_request;
  logic        out_rearm_receiver;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  tag_shadow sb;

  contactless_tag_target_responder_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_frame_length     (in_frame_length),
    .in_first_byte       (in_first_byte),
    .in_second_byte      (in_second_byte),
    .in_data_word        (in_data_word),
    .in_load_index       (in_load_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_new_state       (out_new_state),
    .out_response_length (out_response_length),
    .out_response_data   (out_response_data),
    .out_delay_class     (out_delay_class),
    .out_save_request    (out_save_request),
    .out_rearm_receiver  (out_rearm_receiver)
  );

  always #5 clk = ~clk;

  // Hold the output off for a long stretch on each new hold request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stall_pct > 0) begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tag_reply_t got;
    if (rst_n && out_valid && out_ready) begin
      got.new_state = out_new_state;
      got.response_length = out_response_length;
      got.response_data = out_response_data;
      got.delay_class = out_delay_class;
      got.save_request = out_save_request;
      got.rearm_receiver = out_rearm_receiver;
      sb.check_reply(got);
    end
  end

  function automatic tag_request_t reader_frame(logic [7:0] len, logic [7:0] b0,
                                                logic [7:0] b1, logic [31:0] w);
    tag_request_t r;
    r.command = CMD_FRAME;
    r.frame_length = len;
    r.first_byte = b0;
    r.second_byte = b1;
    r.data_word = w;
    r.load_index = 8'($urandom);
    return r;
  endfunction

  function automatic tag_request_t host_load(logic [7:0] idx, logic [31:0] w);
    tag_request_t r;
    r = reader_frame(8'($urandom), 8'($urandom), 8'($urandom), w);
    r.command = CMD_LOAD;
    r.load_index = idx;
    return r;
  endfunction

  function automatic logic [7:0] random_address();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return 8'($urandom_range(N_BLOCKS - 1));
    if (sel < 75) return ALIAS_ADDR;
    if (sel < 85) return SAVE_ADDR;
    return 8'($urandom);
  endfunction

  // Mostly frames that are legal in the shadow's present state.
  function automatic tag_request_t random_request();
    tag_request_t r;
    int pick;
    int sub;
    int target;
    logic [3:0] hi;
    pick = $urandom_range(99);
    sub = $urandom_range(99);
    hi = 4'($urandom);
    r = reader_frame(($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom),
                     8'($urandom), 8'($urandom), $urandom);
    if (pick < 8) begin
      r.command = CMD_LOAD;
      if ($urandom_range(3) != 0) r.load_index = 8'($urandom_range(N_BLOCKS - 1));
    end else if (pick < 10) begin
      r.command = CMD_RESET;
    end else if (pick < 11) begin
      r.command = CMD_UNUSED;
    end else if (pick >= 21) begin
      case (sb.tag_state)
        ST_INVENTORY, ST_DESELECTED: begin
          if (sub < 50) begin
            r = reader_frame(8'd2, OP_SELECT, sb.chip_id, $urandom);
          end else if (sub < 65) begin
            r = reader_frame(8'd2, OP_SELECT, 8'($urandom), $urandom);
          end else begin
            r = reader_frame(8'($urandom_range(1, 255)), {hi, 4'h0} | OP_SLOT_CODE,
                             8'($urandom), $urandom);
          end
        end
        ST_SELECTED: begin
          if (sub < 15) r = reader_frame(8'd1, OP_GET_UID, 8'($urandom), $urandom);
          else if (sub < 45) r = reader_frame(8'd2, OP_READ, random_address(), $urandom);
          else if (sub < 80) r = reader_frame(8'd6, OP_WRITE, random_address(), $urandom);
          else if (sub < 85) r = reader_frame(8'd1, OP_RESET_INV, 8'($urandom), $urandom);
          else if (sub < 90) r = reader_frame(8'd1, OP_COMPLETION, 8'($urandom), $urandom);
        end
        default: r = reader_frame(8'd2, OP_INITIATE, 8'($urandom), $urandom);
      endcase
    end
    target = sb.unread_block(r);
    if (target >= 0) r = host_load(8'(target), $urandom);
    return r;
  endfunction

  task automatic send_request(tag_request_t r);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= r.command;
    in_frame_length <= r.frame_length;
    in_first_byte <= r.first_byte;
    in_second_byte <= r.second_byte;
    in_data_word <= r.data_word;
    in_load_index <= r.load_index;
    do @(posedge clk); while (!in_ready);
    sb.take_request(r);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_chip_id(logic [7:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.chip_id = v;
  endtask

  task automatic run_directed();
    send_request(host_load(8'd0, 32'h0000_0000));
    send_request(host_load(8'(N_BLOCKS - 1), 32'hffff_ffff));
    send_request(host_load(8'(UID_BLK), 32'h1234_5678));
    send_request(host_load(8'(SYS_BLOCK), 32'ha5a5_a5a5));
    send_request(host_load(8'hff, 32'hdead_beef));
    send_request(host_load(8'(N_BLOCKS), 32'h0bad_f00d));
    send_request(reader_frame(8'd0, 8'h00, 8'h00, 32'h0));
    send_request(reader_frame(8'hff, 8'hff, 8'hff, 32'hffff_ffff));
    send_request(reader_frame(8'd2, OP_INITIATE, 8'h00, 32'h0));
    send_request(reader_frame(8'hff, 8'hf0 | OP_SLOT_CODE, 8'h00, 32'h0));
    send_request(reader_frame(8'd2, OP_SELECT, CHIP_ID_RESET + 8'd1, 32'h0));
    send_request(reader_frame(8'd2, OP_SELECT, CHIP_ID_RESET, 32'h0));
    send_request(reader_frame(8'd1, OP_GET_UID, 8'h00, 32'h0));
    send_request(reader_frame(8'd2, OP_READ, ALIAS_ADDR, 32'h0));
    send_request(reader_frame(8'd2, OP_READ, 8'(N_BLOCKS - 1), 32'h0));
    send_request(reader_frame(8'd2, OP_READ, 8'(N_BLOCKS), 32'h0));
    send_request(reader_frame(8'd6, OP_WRITE, 8'd0, 32'hffff_ffff));
    send_request(reader_frame(8'd6, OP_WRITE, ALIAS_ADDR, 32'h0));
    send_request(reader_frame(8'd6, OP_WRITE, SAVE_ADDR, 32'h0));
    send_request(reader_frame(8'd3, 8'h55, 8'h00, 32'h0));
    send_request(reader_frame(8'd1, OP_RESET_INV, 8'h00, 32'h0));
    send_request(reader_frame(8'd1, 8'h00, 8'h00, 32'h0));
    send_request(reader_frame(8'd2, OP_INITIATE, 8'h00, 32'h0));
    send_request(reader_frame(8'd2, OP_SELECT, CHIP_ID_RESET, 32'h0));
    send_request(reader_frame(8'd1, OP_COMPLETION, 8'h00, 32'h0));
    send_request(reader_frame(8'd2, OP_INITIATE, 8'h00, 32'h0));
    send_request(reader_frame(8'd2, OP_INITIATE, 8'h00, 32'h0));
    send_request(host_load(8'd1, 32'h0));
    send_request(reader_frame(8'd1, 8'h00, 8'h00, 32'h0));
    sb.tag_state = sb.tag_state;
    send_request('{command: CMD_RESET, frame_length: 8'h00, first_byte: 8'h00,
                   second_byte: 8'h00, data_word: 32'h0, load_index: 8'h00});
    send_request('{command: CMD_UNUSED, frame_length: 8'hff, first_byte: 8'hff,
                   second_byte: 8'hff, data_word: 32'hffff_ffff, load_index: 8'h00});
  endtask

  initial begin
    logic [7:0] chips [5];
    int tx_modes [5];
    int rx_modes [5];
    sb = new();
    chips = '{8'h00, 8'hff, 8'($urandom), 8'($urandom), CHIP_ID_RESET};
    tx_modes = '{0, 61, 0, 38, 0};
    rx_modes = '{0, 0, 61, 38, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 5; p++) begin
      write_chip_id(chips[p]);
      tx_idle_pct = tx_modes[p];
      rx_stall_pct = rx_modes[p];
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (p == 4 && i == 20) hold_req <= hold_req + 1;
        send_request(random_request());
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    $display("Checked %0d requests: %0d chip id, %0d UID, %0d block and %0d save replies.",
             sb.requests, sb.chip_replies, sb.uid_replies, sb.block_replies, sb.saves);
    $display("Chip id settings 0x00, 0xff, two random, 0x42; idle, stall and hold-off modes.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
src/cttr_pkg.sv
src/cttr_front.sv
src/cttr_queue.sv
src/cttr_back.sv
src/contactless_tag_target_responder_top.sv
src/cttr_checker.sv
tb/tb_top.sv
